>>> src/sha_pkg.sv
// Shared types, constants and functions for the SHA-256 stream hasher.
// No dependencies.
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 64;
  localparam int unsigned BlkWords = 16;
  localparam logic [7:0] PadByte = 8'h80;

  typedef struct packed {
    logic       wr_byte;
    logic       pad;
    logic       pad2;
    logic       load_v;
    logic       round;
    logic       add;
    logic       clear;
    logic [5:0] rnd;
    logic [2:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic two_blk;
  } status_t;

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    unique case (i)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;  6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5;  6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;  6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01;  6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> src/sha_if.sv
// Valid/ready channel interfaces for message bytes and digest words.
// No dependencies.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       msg_end;
  modport source(output valid, data_byte, byte_valid, msg_end, input ready);
  modport sink(input valid, data_byte, byte_valid, msg_end, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        final_word;
  modport source(output valid, digest_word, word_index, final_word, input ready);
  modport sink(input valid, digest_word, word_index, final_word, output ready);
endinterface

>>> src/sha_dp.sv
// SHA-256 datapath: block words / message schedule, working variables,
// chaining state, fill count and length. Depends on sha_pkg.
module sha_dp
  import sha_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  input  logic [7:0]    data_byte,
  output status_t       status,
  output logic [31:0]   digest_word
);

  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] w [BlkWords];
  logic [5:0]  fill;
  logic [60:0] len;

  logic [63:0] bits;
  logic [31:0] t1, t2, s0, s1, w_new;
  logic [31:0] pw [BlkWords];

  function automatic logic [31:0] pad_word(input logic [31:0] x, input logic [3:0] j,
                                           input logic [5:0] f);
    logic [31:0] r;
    logic [5:0]  b;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      b = {j, 2'(k)};
      if (b < f) r[31-8*k -: 8] = x[31-8*k -: 8];
      else if (b == f) r[31-8*k -: 8] = PadByte;
    end
    return r;
  endfunction

  assign bits = {len, 3'b000};
  assign status.full = (fill == 6'd63);
  assign status.two_blk = (fill >= 6'd56);
  assign digest_word = h[cmd.out_idx];

  always_comb begin
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(cmd.rnd) + w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    for (int j = 0; j < BlkWords; j++) begin
      pw[j] = pad_word(w[j], 4'(j), fill);
    end
    if (!status.two_blk) begin
      pw[14] = bits[63:32];
      pw[15] = bits[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      case (fill[1:0])
        2'd0: w[fill[5:2]][31:24] <= data_byte;
        2'd1: w[fill[5:2]][23:16] <= data_byte;
        2'd2: w[fill[5:2]][15:8]  <= data_byte;
        default: w[fill[5:2]][7:0] <= data_byte;
      endcase
    end
    if (cmd.pad) begin
      for (int j = 0; j < BlkWords; j++) w[j] <= pw[j];
    end
    if (cmd.pad2) begin
      for (int j = 0; j < 14; j++) w[j] <= '0;
      w[14] <= bits[63:32];
      w[15] <= bits[31:0];
    end
    if (cmd.load_v) begin
      for (int i = 0; i < 8; i++) v[i] <= h[i];
    end
    if (cmd.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
      for (int j = 0; j < BlkWords - 1; j++) w[j] <= w[j+1];
      w[BlkWords-1] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill <= '0;
      len  <= '0;
      for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
    end else begin
      if (cmd.wr_byte) begin
        fill <= fill + 6'd1;
        len  <= len + 61'd1;
      end
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
      end
    end
  end

endmodule

>>> src/sha_ctrl.sv
// SHA-256 controller: sequences byte intake, padding, rounds and digest output.
// Depends on sha_pkg and the channel interfaces.
module sha_ctrl
  import sha_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  sha_in_if.sink          in_ch,
  sha_out_if.source       out_ch,
  input  status_t         status,
  output cmd_t            cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_ROUND = 6'b000100,
    S_ADD   = 6'b001000,
    S_PAD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    T_NONE = 2'd0,
    T_TWO  = 2'd1,
    T_LAST = 2'd2
  } tail_t;

  state_t      state, state_next;
  tail_t       tail, tail_next;
  logic        end_pend, end_pend_next;
  logic [5:0]  rnd, rnd_next;
  logic [2:0]  idx, idx_next;
  logic        in_xfer, out_xfer;

  assign in_ch.ready  = (state == S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (state == S_OUT);
  assign out_xfer     = out_ch.valid && out_ch.ready;
  assign out_ch.word_index = idx;
  assign out_ch.final_word = (idx == 3'd7);

  always_comb begin
    state_next    = state;
    tail_next     = tail;
    end_pend_next = end_pend;
    rnd_next      = rnd;
    idx_next      = idx;
    cmd           = '0;
    cmd.rnd       = rnd;
    cmd.out_idx   = idx;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.wr_byte = in_ch.byte_valid;
          end_pend_next = in_ch.msg_end;
          if (in_ch.byte_valid && status.full) state_next = S_LOAD;
          else if (in_ch.msg_end) state_next = S_PAD;
        end
      end
      S_LOAD: begin
        cmd.load_v = 1'b1;
        rnd_next = '0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_next = rnd + 6'd1;
        if (rnd == 6'(Rounds - 1)) state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (!end_pend) begin
          state_next = S_IDLE;
        end else if (tail == T_NONE) begin
          state_next = S_PAD;
        end else if (tail == T_TWO) begin
          cmd.pad2 = 1'b1;
          tail_next = T_LAST;
          state_next = S_LOAD;
        end else begin
          idx_next = '0;
          state_next = S_OUT;
        end
      end
      S_PAD: begin
        cmd.pad = 1'b1;
        tail_next = status.two_blk ? T_TWO : T_LAST;
        state_next = S_LOAD;
      end
      S_OUT: begin
        if (out_xfer) begin
          idx_next = idx + 3'd1;
          if (idx == 3'd7) begin
            cmd.clear = 1'b1;
            end_pend_next = 1'b0;
            tail_next = T_NONE;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tail     <= T_NONE;
      end_pend <= 1'b0;
      rnd      <= '0;
      idx      <= '0;
    end else begin
      state    <= state_next;
      tail     <= tail_next;
      end_pend <= end_pend_next;
      rnd      <= rnd_next;
      idx      <= idx_next;
    end
  end

  a_add_after_last_round: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD |-> $past(rnd) == 6'(Rounds - 1))
    else $error("add without full round count");
  a_out_needs_end: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> end_pend && tail == T_LAST)
    else $error("digest output without message end");
  a_last_word_idle: assert property (@(posedge clk) disable iff (rst)
    out_xfer && idx == 3'd7 |=> state == S_IDLE && !end_pend)
    else $error("no return to idle after last word");

endmodule

>>> src/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: controller plus datapath.
// Depends on sha_pkg, sha_if, sha_ctrl and sha_dp.
//
// in_ch carries one item per transfer: data_byte with byte_valid, and
// msg_end to close the message (an end item may carry no byte; sent alone,
// such an item hashes an empty message). out_ch returns the digest as eight 32-bit
// big-endian words, word_index 0..7, final_word high on the last.
// A byte that does not complete a block is taken in idle. The byte that
// completes a 64-byte block is followed by load, 64 rounds and add, set
// by the single round unit doing one round per cycle; no byte is taken
// meanwhile. An end item is followed by pad, load, 64 rounds and add for
// the first tail block, and by load, 64 rounds and add for a second one
// (needed when 56 or more bytes sit in the buffer) before the first digest
// word is shown; words then move one per cycle while out_ch.ready is high.
// A stalled receiver holds the current word; no input is taken until all
// eight words have gone, after which the block is back in its initial
// state. Synchronous reset rst restores the initial hash values and
// clears the fill count and length.
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  sha_in_if.sink     in_ch,
  sha_out_if.source  out_ch
);

  cmd_t    cmd;
  status_t status;

  sha_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .status (status),
    .cmd    (cmd)
  );

  sha_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (in_ch.data_byte),
    .status      (status),
    .digest_word (out_ch.digest_word)
  );

endmodule
